>>> rtl/mgp_pkg.sv
// Shared types, constants and helpers for the Mandelbrot grayscale pixel core.
`timescale 1ns / 1ps

package mgp_pkg;

	localparam int FRAC_BITS = 28;
	localparam int COORD_W   = 32;
	localparam int ITER_W    = 16;
	localparam int XRES_W    = 13;
	localparam int PIX_W     = 12;
	localparam int GRAY_W    = 8;
	localparam int CFG_IDX_W = 3;

	// divider: numerator is width times height span, divisor a span
	localparam int NUM_W      = XRES_W + COORD_W;
	localparam int DEN_W      = COORD_W;
	localparam int STEP_CNT_W = $clog2(NUM_W + 1);

	// point, squared terms and iterate sums
	localparam int C_W   = COORD_W + PIX_W + 2;
	localparam int SQ_W  = 2 * COORD_W - FRAC_BITS + 2;
	localparam int SUM_W = ((SQ_W > C_W) ? SQ_W : C_W) + 2;

	localparam logic signed [SUM_W-1:0] ESC_LIMIT = SUM_W'(4) << FRAC_BITS;

	localparam logic [GRAY_W-1:0] GRAY_FULL     = 8'd255;
	localparam logic [ITER_W-1:0] PREVIEW_FLOOR = 16'd10;

	localparam logic [CFG_IDX_W-1:0] REG_X_MIN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_MAX    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Y_MIN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_MAX    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_X_RES    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PREVIEW  = 3'd6;

	localparam logic [COORD_W-1:0] X_MIN_RST    = 32'hE000_0000;
	localparam logic [COORD_W-1:0] X_MAX_RST    = 32'h1000_0000;
	localparam logic [COORD_W-1:0] Y_MIN_RST    = 32'hE800_0000;
	localparam logic [COORD_W-1:0] Y_MAX_RST    = 32'h1800_0000;
	localparam logic [ITER_W-1:0]  MAX_ITER_RST = 16'd256;
	localparam logic [XRES_W-1:0]  X_RES_RST    = 13'd1024;

	typedef enum logic [1:0] {
		DIV_HEIGHT,
		DIV_STEP_X,
		DIV_STEP_Y,
		DIV_GRAY
	} div_sel_t;

	typedef struct packed {
		logic     cfg_wr;
		logic     span_ld;
		logic     prod_ld;
		logic     deg_set;
		logic     div_start;
		div_sel_t div_sel;
		logic     h_ld;
		logic     sx_ld;
		logic     sy_ld;
		logic     pix_ld;
		logic     c_mul;
		logic     c_add;
		logic     iter_add;
		logic     iter_mul;
		logic     gray_ld;
		logic     out_ld;
	} mgp_cmd_t;

	typedef struct packed {
		logic span_bad;
		logic div_done;
		logic h_zero;
		logic oor;
		logic go_on;
		logic interior;
	} mgp_sts_t;

	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] x);
		if (x[SUM_W-1:COORD_W-1] == '0 || x[SUM_W-1:COORD_W-1] == '1)
			sat_coord = x[COORD_W-1:0];
		else if (x[SUM_W-1])
			sat_coord = {1'b1, {(COORD_W-1){1'b0}}};
		else
			sat_coord = {1'b0, {(COORD_W-1){1'b1}}};
	endfunction

endpackage

>>> rtl/mgp_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module mgp_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [mgp_pkg::DEN_W-1:0]        rem_init,
	input  logic [mgp_pkg::NUM_W-1:0]        num,
	input  logic [mgp_pkg::DEN_W-1:0]        den,
	input  logic [mgp_pkg::STEP_CNT_W-1:0]   steps,
	output logic [mgp_pkg::NUM_W-1:0]        quot,
	output logic                             done
);

	logic                              busy_q;
	logic                              done_q;
	logic [mgp_pkg::STEP_CNT_W-1:0]    cnt_q;
	logic [mgp_pkg::DEN_W-1:0]         rem_q;
	logic [mgp_pkg::DEN_W-1:0]         den_q;
	logic [mgp_pkg::NUM_W-1:0]         num_q;
	logic [mgp_pkg::NUM_W-1:0]         quot_q;
	logic [mgp_pkg::DEN_W:0]           trial;
	logic                              fits;

	assign trial = {rem_q, num_q[mgp_pkg::NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == mgp_pkg::STEP_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= rem_init;
			num_q  <= num;
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			if (fits)
				rem_q <= mgp_pkg::DEN_W'(trial - {1'b0, den_q});
			else
				rem_q <= mgp_pkg::DEN_W'(trial);
			num_q  <= num_q << 1;
			quot_q <= {quot_q[mgp_pkg::NUM_W-2:0], fits};
		end
	end

	assign quot = quot_q;
	assign done = done_q;

	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");

	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(busy_q))
		else $error("divider done without a run");

endmodule

>>> rtl/mgp_datapath.sv
// Datapath: registers, setup arithmetic, escape iteration and result register.
`timescale 1ns / 1ps

module mgp_datapath #(
	parameter int MAX_RES = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mgp_pkg::mgp_cmd_t                   cmd,
	output mgp_pkg::mgp_sts_t                   sts,
	input  logic [mgp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mgp_pkg::COORD_W-1:0]         cfg_data,
	input  logic [2*mgp_pkg::PIX_W-1:0]         pix_data,
	output logic [mgp_pkg::ITER_W+mgp_pkg::GRAY_W-1:0] res_data,
	output logic [1:0]                          res_user
);

	localparam int H_W = $clog2(MAX_RES + 1);
	localparam int CW  = mgp_pkg::COORD_W;
	localparam int IW  = mgp_pkg::ITER_W;
	localparam int GW  = mgp_pkg::GRAY_W;
	localparam int PW  = mgp_pkg::PIX_W;
	localparam int XW  = mgp_pkg::XRES_W;
	localparam int NW  = mgp_pkg::NUM_W;
	localparam int DW  = mgp_pkg::DEN_W;
	localparam int SW  = mgp_pkg::SUM_W;
	localparam int QW  = mgp_pkg::SQ_W;
	localparam int CCW = mgp_pkg::C_W;

	// configuration
	logic signed [CW-1:0] x_min_q, x_max_q, y_min_q, y_max_q;
	logic [IW-1:0]        max_iter_q;
	logic [XW-1:0]        x_res_q;
	logic                 preview_q;

	// derived setup
	logic signed [CW:0]   wspan_q, hspan_q;
	logic [XW-1:0]        eff_w_q;
	logic [IW-1:0]        limit_q;
	logic [NW-1:0]        prod_q;
	logic [H_W-1:0]       height_q;
	logic [CW-1:0]        step_x_q, step_y_q;
	logic                 deg_q;

	logic signed [CW:0]   wspan_d, hspan_d;
	logic [XW-1:0]        eff_w_d;
	logic [IW-1:0]        limit_d;
	logic [H_W-1:0]       h_sat;

	// pixel and iteration
	logic [PW-1:0]          col_q, row_q;
	logic [CW+PW-1:0]       cx_prod_q, cy_prod_q;
	logic signed [CCW-1:0]  cre_q, cim_q;
	logic signed [CW-1:0]   u_q, v_q;
	logic signed [QW-1:0]   u2_q, v2_q, uv_q;
	logic [IW-1:0]          k_q;
	logic [GW-1:0]          gray_q;
	logic signed [2*CW-1:0] uu, vv, uvp;
	logic signed [SW-1:0]   nu, nv, mag2;
	logic [IW+GW-1:0]       kg;
	logic                   oor, interior;

	// result register
	logic [IW-1:0] res_iter_q;
	logic [GW-1:0] res_gray_q;
	logic          res_int_q;
	logic          res_oor_q;

	// divider
	logic [DW-1:0]                  div_rem;
	logic [NW-1:0]                  div_num;
	logic [DW-1:0]                  div_den;
	logic [mgp_pkg::STEP_CNT_W-1:0] div_steps;
	logic [NW-1:0]                  quot;
	logic                           div_done;

	always_comb begin
		wspan_d = (CW+1)'(x_max_q) - (CW+1)'(x_min_q);
		hspan_d = (CW+1)'(y_max_q) - (CW+1)'(y_min_q);
		if (32'(x_res_q) > 32'(MAX_RES))
			eff_w_d = XW'(MAX_RES);
		else
			eff_w_d = x_res_q;
		limit_d = max_iter_q;
		if (preview_q) begin
			limit_d = {2'b00, max_iter_q[IW-1:2]};
			if (limit_d < mgp_pkg::PREVIEW_FLOOR)
				limit_d = mgp_pkg::PREVIEW_FLOOR;
		end
		if (quot > NW'(MAX_RES))
			h_sat = H_W'(MAX_RES);
		else
			h_sat = H_W'(quot);
	end

	assign kg = {{GW{1'b0}}, k_q} * {{IW{1'b0}}, mgp_pkg::GRAY_FULL};

	always_comb begin
		unique case (cmd.div_sel)
			mgp_pkg::DIV_HEIGHT: begin
				div_rem   = '0;
				div_num   = prod_q;
				div_den   = wspan_q[CW-1:0];
				div_steps = mgp_pkg::STEP_CNT_W'(NW);
			end
			mgp_pkg::DIV_STEP_X: begin
				div_rem   = '0;
				div_num   = NW'(wspan_q[CW-1:0]);
				div_den   = DW'(eff_w_q);
				div_steps = mgp_pkg::STEP_CNT_W'(NW);
			end
			mgp_pkg::DIV_STEP_Y: begin
				div_rem   = '0;
				div_num   = NW'(hspan_q[CW-1:0]);
				div_den   = DW'(height_q);
				div_steps = mgp_pkg::STEP_CNT_W'(NW);
			end
			default: begin
				div_rem   = DW'(kg[IW+GW-1:GW]);
				div_num   = {kg[GW-1:0], {(NW-GW){1'b0}}};
				div_den   = DW'(limit_q);
				div_steps = mgp_pkg::STEP_CNT_W'(GW);
			end
		endcase
	end

	mgp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.rem_init (div_rem),
		.num      (div_num),
		.den      (div_den),
		.steps    (div_steps),
		.quot     (quot),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q    <= mgp_pkg::X_MIN_RST;
			x_max_q    <= mgp_pkg::X_MAX_RST;
			y_min_q    <= mgp_pkg::Y_MIN_RST;
			y_max_q    <= mgp_pkg::Y_MAX_RST;
			max_iter_q <= mgp_pkg::MAX_ITER_RST;
			x_res_q    <= mgp_pkg::X_RES_RST;
			preview_q  <= 1'b0;
			wspan_q    <= '0;
			hspan_q    <= '0;
			eff_w_q    <= '0;
			limit_q    <= '0;
			height_q   <= '0;
			step_x_q   <= '0;
			step_y_q   <= '0;
			deg_q      <= 1'b1;
		end else begin
			if (cmd.cfg_wr) begin
				unique case (cfg_index)
					mgp_pkg::REG_X_MIN:    x_min_q    <= cfg_data;
					mgp_pkg::REG_X_MAX:    x_max_q    <= cfg_data;
					mgp_pkg::REG_Y_MIN:    y_min_q    <= cfg_data;
					mgp_pkg::REG_Y_MAX:    y_max_q    <= cfg_data;
					mgp_pkg::REG_MAX_ITER: max_iter_q <= cfg_data[IW-1:0];
					mgp_pkg::REG_X_RES:    x_res_q    <= cfg_data[XW-1:0];
					mgp_pkg::REG_PREVIEW:  preview_q  <= cfg_data[0];
					default: begin
					end
				endcase
			end
			if (cmd.span_ld) begin
				wspan_q <= wspan_d;
				hspan_q <= hspan_d;
				eff_w_q <= eff_w_d;
				limit_q <= limit_d;
			end
			if (cmd.deg_set) begin
				deg_q    <= 1'b1;
				height_q <= '0;
				step_x_q <= '0;
				step_y_q <= '0;
			end
			if (cmd.h_ld)
				height_q <= h_sat;
			if (cmd.sx_ld)
				step_x_q <= quot[CW-1:0];
			if (cmd.sy_ld) begin
				step_y_q <= quot[CW-1:0];
				deg_q    <= 1'b0;
			end
		end
	end

	assign oor = deg_q || ({1'b0, col_q} >= eff_w_q) || (32'(row_q) >= 32'(height_q));

	assign uu   = u_q * u_q;
	assign vv   = v_q * v_q;
	assign uvp  = u_q * v_q;
	assign nu   = SW'(u2_q) - SW'(v2_q) + SW'(cre_q);
	assign nv   = SW'(uv_q) + SW'(cim_q);
	assign mag2 = SW'(u2_q) + SW'(v2_q);

	assign interior = k_q >= limit_q;

	always_ff @(posedge clk) begin
		if (cmd.prod_ld)
			prod_q <= {{CW{1'b0}}, eff_w_q} * {{XW{1'b0}}, hspan_q[CW-1:0]};
		if (cmd.pix_ld) begin
			col_q <= pix_data[PW-1:0];
			row_q <= pix_data[2*PW-1:PW];
		end
		if (cmd.c_mul) begin
			cx_prod_q <= {{PW{1'b0}}, step_x_q} * {{CW{1'b0}}, col_q};
			cy_prod_q <= {{PW{1'b0}}, step_y_q} * {{CW{1'b0}}, row_q};
		end
		if (cmd.c_add) begin
			cre_q <= CCW'(x_min_q) + signed'({{(CCW-CW-PW){1'b0}}, cx_prod_q});
			cim_q <= CCW'(y_max_q) - signed'({{(CCW-CW-PW){1'b0}}, cy_prod_q});
			u_q   <= '0;
			v_q   <= '0;
			u2_q  <= '0;
			v2_q  <= '0;
			uv_q  <= '0;
			k_q   <= IW'(1);
		end
		if (cmd.iter_add) begin
			u_q <= mgp_pkg::sat_coord(nu);
			v_q <= mgp_pkg::sat_coord(nv);
			k_q <= k_q + 1'b1;
		end
		if (cmd.iter_mul) begin
			u2_q <= QW'(uu >>> mgp_pkg::FRAC_BITS);
			v2_q <= QW'(vv >>> mgp_pkg::FRAC_BITS);
			uv_q <= QW'(uvp >>> (mgp_pkg::FRAC_BITS - 1));
		end
		if (cmd.gray_ld)
			gray_q <= quot[GW-1:0];
		if (cmd.out_ld) begin
			res_iter_q <= oor ? '0 : k_q;
			res_gray_q <= (oor || interior) ? '0 : gray_q;
			res_int_q  <= !oor && interior;
			res_oor_q  <= oor;
		end
	end

	always_comb begin
		sts.span_bad = (wspan_q <= 0) || (hspan_q <= 0) || (eff_w_q == '0);
		sts.div_done = div_done;
		sts.h_zero   = quot == '0;
		sts.oor      = oor;
		sts.go_on    = (k_q < limit_q) && (mag2 < mgp_pkg::ESC_LIMIT);
		sts.interior = interior;
	end

	assign res_data = {res_gray_q, res_iter_q};
	assign res_user = {res_oor_q, res_int_q};

	a_iter_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.iter_add |-> (k_q < limit_q) && (mag2 < mgp_pkg::ESC_LIMIT))
		else $error("iteration step past limit or escape");

	a_height_set: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sy_ld |-> height_q != '0)
		else $error("row step derived from zero height");

endmodule

>>> rtl/mgp_ctrl.sv
// Controller: setup sequence, pixel sequence and output slot handshake.
`timescale 1ns / 1ps

module mgp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output mgp_pkg::mgp_cmd_t cmd,
	input  mgp_pkg::mgp_sts_t sts
);

	localparam logic [3:0] S_SPAN     = 4'd0;
	localparam logic [3:0] S_PROD     = 4'd1;
	localparam logic [3:0] S_H_GO     = 4'd2;
	localparam logic [3:0] S_DIV_H    = 4'd3;
	localparam logic [3:0] S_DIV_SX   = 4'd4;
	localparam logic [3:0] S_DIV_SY   = 4'd5;
	localparam logic [3:0] S_IDLE     = 4'd6;
	localparam logic [3:0] S_PIX_C    = 4'd7;
	localparam logic [3:0] S_PIX_ADD  = 4'd8;
	localparam logic [3:0] S_ITER_ADD = 4'd9;
	localparam logic [3:0] S_ITER_MUL = 4'd10;
	localparam logic [3:0] S_DIV_G    = 4'd11;
	localparam logic [3:0] S_FINISH   = 4'd12;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;

	assign cfg_ready = state_q == S_IDLE;
	assign in_ready  = (state_q == S_IDLE) && !cfg_valid;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_SPAN: begin
				cmd.span_ld = 1'b1;
				state_d     = S_PROD;
			end
			S_PROD: begin
				if (sts.span_bad) begin
					cmd.deg_set = 1'b1;
					state_d     = S_IDLE;
				end else begin
					cmd.prod_ld = 1'b1;
					state_d     = S_H_GO;
				end
			end
			S_H_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = mgp_pkg::DIV_HEIGHT;
				state_d       = S_DIV_H;
			end
			S_DIV_H: begin
				if (sts.div_done) begin
					if (sts.h_zero) begin
						cmd.deg_set = 1'b1;
						state_d     = S_IDLE;
					end else begin
						cmd.h_ld      = 1'b1;
						cmd.div_start = 1'b1;
						cmd.div_sel   = mgp_pkg::DIV_STEP_X;
						state_d       = S_DIV_SX;
					end
				end
			end
			S_DIV_SX: begin
				if (sts.div_done) begin
					cmd.sx_ld     = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel   = mgp_pkg::DIV_STEP_Y;
					state_d       = S_DIV_SY;
				end
			end
			S_DIV_SY: begin
				if (sts.div_done) begin
					cmd.sy_ld = 1'b1;
					state_d   = S_IDLE;
				end
			end
			S_IDLE: begin
				if (cfg_valid) begin
					cmd.cfg_wr = 1'b1;
					state_d    = S_SPAN;
				end else if (in_valid) begin
					cmd.pix_ld = 1'b1;
					state_d    = S_PIX_C;
				end
			end
			S_PIX_C: begin
				if (sts.oor) begin
					state_d = S_FINISH;
				end else begin
					cmd.c_mul = 1'b1;
					state_d   = S_PIX_ADD;
				end
			end
			S_PIX_ADD: begin
				cmd.c_add = 1'b1;
				state_d   = S_ITER_ADD;
			end
			S_ITER_ADD: begin
				if (sts.go_on) begin
					cmd.iter_add = 1'b1;
					state_d      = S_ITER_MUL;
				end else if (sts.interior) begin
					state_d = S_FINISH;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = mgp_pkg::DIV_GRAY;
					state_d       = S_DIV_G;
				end
			end
			S_ITER_MUL: begin
				cmd.iter_mul = 1'b1;
				state_d      = S_ITER_ADD;
			end
			S_DIV_G: begin
				if (sts.div_done) begin
					cmd.gray_ld = 1'b1;
					state_d     = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_SPAN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SPAN;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_ld)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	a_one_accept: assert property (@(posedge clk) disable iff (!arst_n)
		!(cfg_valid && cfg_ready && in_valid && in_ready))
		else $error("config write and item taken together");

	a_item_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_PIX_C)
		else $error("accepted item not started");

endmodule

>>> rtl/mandelbrot_gray_pixel_core.sv
// Top level of the Mandelbrot escape-time grayscale pixel core.
// An out-of-range item goes from the range check straight to the result register; an
// in-range item runs the multiply/add iteration loop, then the gray division if it escapes.
// Items are taken one at a time: no new item is accepted until the last result is registered.
// Reset and every config write start a setup pass (up to three 45-step divisions)
// with neither channel ready; reset restores the default window.
`timescale 1ns / 1ps

module mandelbrot_gray_pixel_core #(
	parameter int MAX_RES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // column[11:0], row[23:12]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // iterations[15:0], gray[23:16]
	output logic [1:0]  m_axis_tuser    // interior[0], out_of_range[1]
);

	mgp_pkg::mgp_cmd_t cmd;
	mgp_pkg::mgp_sts_t sts;

	mgp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	mgp_datapath #(
		.MAX_RES (MAX_RES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_data  (s_axis_tdata),
		.res_data  (m_axis_tdata),
		.res_user  (m_axis_tuser)
	);

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the Mandelbrot grayscale pixel core.
`timescale 1ns / 1ps

module testbench;
	import mgp_pkg::*;

	localparam int MAX_RES      = 4096;
	localparam int RANDOM_ITEMS = 730;
	localparam int CALM_ITEMS   = 100;
	localparam int RUN_LIMIT    = 5_000_000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [ITER_W-1:0] iterations;
		logic [GRAY_W-1:0] gray;
		logic              interior;
		logic              out_of_range;
	} pixel_res_t;

	localparam pixel_res_t PIX_OOR = {16'd0, 8'd0, 1'b0, 1'b1};

	typedef enum bit {ROW_PIXEL, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [31:0]           data;
		logic [PIX_W-1:0]      col;
		logic [PIX_W-1:0]      row;
		bit                    typed;
		pixel_res_t            res;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;   // column[11:0], row[23:12]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;   // iterations[15:0], gray[23:16]
	logic [1:0]  m_axis_tuser;   // interior[0], out_of_range[1]

	// window, limit and derived geometry as the core should hold them
	logic signed [31:0]  win_x_min, win_x_max, win_y_min, win_y_max;
	logic [ITER_W-1:0]   reg_max_iter;
	logic [XRES_W-1:0]   reg_x_res;
	logic                reg_preview;
	logic [31:0]         step_x, step_y;
	int                  img_height, eff_width;
	logic [ITER_W-1:0]   iter_limit;
	bit                  window_bad;
	logic signed [31:0]  last_z_re, last_z_im;

	pixel_res_t expected_pixels[$];
	stim_row_t  directed_rows[$];
	int         mismatches = 0;
	int         cycle_count = 0;
	int         rx_stall = 0;
	bit         calm = 1'b0;

	mandelbrot_gray_pixel_core #(.MAX_RES(MAX_RES)) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void derive_geometry();
		longint wspan, hspan, h;
		logic [ITER_W-1:0] m;
		wspan = longint'(win_x_max) - longint'(win_x_min);
		hspan = longint'(win_y_max) - longint'(win_y_min);
		m = reg_max_iter;
		if (reg_preview) begin
			m = m >> 2;
			if (m < PREVIEW_FLOOR)
				m = PREVIEW_FLOOR;
		end
		iter_limit = m;
		eff_width = (reg_x_res > MAX_RES) ? MAX_RES : int'(reg_x_res);
		step_x = '0;
		step_y = '0;
		img_height = 0;
		window_bad = 1'b1;
		if (wspan <= 0 || hspan <= 0 || eff_width == 0)
			return;
		h = (longint'(eff_width) * hspan) / wspan;
		if (h > MAX_RES)
			h = MAX_RES;
		if (h <= 0)
			return;
		img_height = int'(h);
		step_x = 32'(wspan / longint'(eff_width));
		step_y = 32'(hspan / h);
		window_bad = 1'b0;
	endfunction

	function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [31:0] val);
		case (idx)
			REG_X_MIN:    win_x_min = val;
			REG_X_MAX:    win_x_max = val;
			REG_Y_MIN:    win_y_min = val;
			REG_Y_MAX:    win_y_max = val;
			REG_MAX_ITER: reg_max_iter = val[ITER_W-1:0];
			REG_X_RES:    reg_x_res = val[XRES_W-1:0];
			REG_PREVIEW:  reg_preview = val[0];
			default:      return;
		endcase
		derive_geometry();
	endfunction

	function automatic longint clamp32(input longint x);
		if (x > 64'sd2147483647)
			return 64'sd2147483647;
		if (x < -64'sd2147483648)
			return -64'sd2147483648;
		return x;
	endfunction

	function automatic pixel_res_t predict_pixel(input logic [PIX_W-1:0] col,
			input logic [PIX_W-1:0] row);
		longint     cre, cim, u, v, u2, v2, nu, nv;
		longint     four;
		int         k;
		pixel_res_t r;
		four = longint'(4) << FRAC_BITS;
		if (window_bad || int'(col) >= eff_width || int'(row) >= img_height)
			return PIX_OOR;
		cre = longint'(win_x_min) + longint'(col) * longint'(step_x);
		cim = longint'(win_y_max) - longint'(row) * longint'(step_y);
		u = 0;
		v = 0;
		u2 = 0;
		v2 = 0;
		for (k = 1; k < int'(iter_limit) && (u2 + v2) < four; k++) begin
			nv = ((u * v) >>> (FRAC_BITS - 1)) + cim;
			nu = u2 - v2 + cre;
			v = clamp32(nv);
			u = clamp32(nu);
			u2 = (u * u) >>> FRAC_BITS;
			v2 = (v * v) >>> FRAC_BITS;
		end
		last_z_re = 32'(u);
		last_z_im = 32'(v);
		r.iterations = k[ITER_W-1:0];
		r.out_of_range = 1'b0;
		if (k >= int'(iter_limit)) begin
			r.gray = '0;
			r.interior = 1'b1;
		end else begin
			r.gray = 8'((longint'(k) * GRAY_FULL) / longint'(iter_limit));
			r.interior = 1'b0;
		end
		return r;
	endfunction

	function automatic void add_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
		stim_row_t s;
		s.kind = ROW_PIXEL;
		s.idx = '0;
		s.data = '0;
		s.col = col;
		s.row = row;
		s.typed = 1'b0;
		s.res = PIX_OOR;
		directed_rows.push_back(s);
	endfunction

	function automatic void add_pixel_typed(input logic [PIX_W-1:0] col,
			input logic [PIX_W-1:0] row, input pixel_res_t res);
		stim_row_t s;
		s.kind = ROW_PIXEL;
		s.idx = '0;
		s.data = '0;
		s.col = col;
		s.row = row;
		s.typed = 1'b1;
		s.res = res;
		directed_rows.push_back(s);
	endfunction

	function automatic void add_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		stim_row_t s;
		s.kind = ROW_WRITE;
		s.idx = idx;
		s.data = val;
		s.col = '0;
		s.row = '0;
		s.typed = 1'b0;
		s.res = PIX_OOR;
		directed_rows.push_back(s);
	endfunction

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		apply_register(idx, val);
		@(posedge clk);
	endtask

	task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row,
			input bit typed, input pixel_res_t res);
		if (!calm && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {row, col};
		do @(posedge clk); while (!s_axis_tready);
		expected_pixels.push_back(typed ? res : predict_pixel(col, row));
	endtask

	task automatic drain_pixels();
		s_axis_tvalid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic random_setup();
		int          cx, cy, hw, hh;
		logic [15:0] mi;
		logic [31:0] xr;
		bit          pv;
		case ($urandom_range(0, 9))
			0: begin
				cfg_write(REG_X_MIN, $urandom());
				cfg_write(REG_X_MAX, $urandom());
				cfg_write(REG_Y_MIN, $urandom());
				cfg_write(REG_Y_MAX, $urandom());
			end
			1: ;
			default: begin
				cx = $urandom_range(0, 805306368) - 603979776;
				cy = $urandom_range(0, 671088640) - 335544320;
				hw = $urandom_range(1, 3) << $urandom_range(12, 27);
				hh = (hw >> 2) * $urandom_range(1, 8) + 1;
				cfg_write(REG_X_MIN, cx - hw);
				cfg_write(REG_X_MAX, cx + hw);
				cfg_write(REG_Y_MIN, cy - hh);
				cfg_write(REG_Y_MAX, cy + hh);
			end
		endcase
		pv = ($urandom_range(0, 3) == 0);
		case ($urandom_range(0, 9))
			0:       mi = $urandom_range(0, 3);
			1: begin
				mi = $urandom_range(40, 1000);
				pv = 1'b1;
			end
			default: mi = $urandom_range(4, 160);
		endcase
		if ($urandom_range(0, 3) != 0)
			cfg_write(REG_MAX_ITER, {16'($urandom()), mi});
		case ($urandom_range(0, 9))
			0:       xr = ($urandom_range(0, 1) != 0) ? 32'd0 : $urandom_range(4097, 8191);
			1, 2:    xr = $urandom_range(257, 4096);
			default: xr = $urandom_range(1, 256);
		endcase
		if ($urandom_range(0, 3) != 0)
			cfg_write(REG_X_RES, {19'($urandom()), xr[XRES_W-1:0]});
		if (pv != reg_preview || $urandom_range(0, 3) == 0)
			cfg_write(REG_PREVIEW, {31'($urandom()), pv});
	endtask

	always @(posedge clk) begin
		pixel_res_t got, want;
		cycle_count++;
		if (cycle_count == RUN_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_pixels.size());
			$display("FAILURE");
			$finish;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[15:0], m_axis_tdata[23:16], m_axis_tuser[0], m_axis_tuser[1]};
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: iter=%0d gray=%0d int=%0b oor=%0b",
						got.iterations, got.gray, got.interior, got.out_of_range);
			end else begin
				want = expected_pixels.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: iter %0d/%0d gray %0d/%0d int %0b/%0b oor %0b/%0b (exp/got)",
							want.iterations, got.iterations, want.gray, got.gray,
							want.interior, got.interior, want.out_of_range, got.out_of_range);
				end
			end
		end
		if (rx_stall > 0) begin
			m_axis_tready <= 1'b0;
			rx_stall--;
		end else if (!calm && $urandom_range(0, 15) == 0) begin
			m_axis_tready <= 1'b0;
			rx_stall = $urandom_range(0, 16);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	initial begin
		int               sent;
		int               n;
		logic [PIX_W-1:0] col, row;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		win_x_min = X_MIN_RST;
		win_x_max = X_MAX_RST;
		win_y_min = Y_MIN_RST;
		win_y_max = Y_MAX_RST;
		reg_max_iter = MAX_ITER_RST;
		reg_x_res = X_RES_RST;
		reg_preview = 1'b0;
		last_z_re = '0;
		last_z_im = '0;
		derive_geometry();

		add_pixel(0, 0);
		add_pixel_typed(683, 512, {16'd256, 8'd0, 1'b1, 1'b0});
		add_pixel(1023, 1023);
		add_pixel_typed(1024, 0, PIX_OOR);
		add_pixel_typed(0, 1024, PIX_OOR);
		add_pixel_typed(4095, 4095, PIX_OOR);
		add_write(REG_MAX_ITER, 32'd0);
		add_pixel_typed(683, 512, {16'd1, 8'd0, 1'b1, 1'b0});
		add_pixel_typed(0, 0, {16'd1, 8'd0, 1'b1, 1'b0});
		add_write(REG_PREVIEW, 32'd1);
		add_pixel_typed(683, 512, {16'd10, 8'd0, 1'b1, 1'b0});
		add_write(REG_MAX_ITER, 32'd39);
		add_pixel(0, 0);
		add_write(REG_MAX_ITER, 32'hFFFF_FFFF);
		add_pixel(0, 0);
		add_write(REG_PREVIEW, 32'd0);
		add_pixel_typed(683, 512, {16'd65535, 8'd0, 1'b1, 1'b0});
		add_write(REG_MAX_ITER, 32'd20);
		add_write(REG_X_MIN, 32'h8000_0000);
		add_write(REG_X_MAX, 32'h7FFF_FFFF);
		add_write(REG_Y_MIN, 32'h8000_0000);
		add_write(REG_Y_MAX, 32'h7FFF_FFFF);
		add_write(REG_X_RES, 32'd4096);
		add_pixel(0, 0);
		add_pixel(4095, 4095);
		add_pixel(2048, 2048);
		add_pixel(1234, 3000);
		add_write(REG_X_RES, 32'd8191);
		add_pixel(4095, 0);
		add_write(REG_X_RES, 32'd0);
		add_pixel_typed(0, 0, PIX_OOR);
		add_write(REG_X_RES, 32'd16);
		add_write(REG_X_MIN, 32'd0);
		add_write(REG_X_MAX, 32'd1);
		add_pixel(15, 4095);
		add_pixel_typed(16, 0, PIX_OOR);
		add_write(REG_X_MAX, 32'd0);
		add_pixel_typed(0, 0, PIX_OOR);
		add_write(REG_X_MAX, 32'h7FFF_FFFF);
		add_write(REG_Y_MAX, 32'h8000_0000);
		add_pixel_typed(0, 0, PIX_OOR);
		add_write(REG_Y_MAX, 32'h8000_0001);
		add_pixel_typed(3, 0, PIX_OOR);
		add_write(REG_UNUSED, 32'hFFFF_FFFF);
		add_pixel_typed(0, 0, PIX_OOR);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				drain_pixels();
				cfg_write(directed_rows[i].idx, directed_rows[i].data);
			end else begin
				send_pixel(directed_rows[i].col, directed_rows[i].row,
					directed_rows[i].typed, directed_rows[i].res);
			end
		end

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			drain_pixels();
			random_setup();
			n = $urandom_range(10, 50);
			repeat (n) begin
				if (window_bad || $urandom_range(0, 6) == 0) begin
					col = $urandom();
					row = $urandom();
				end else begin
					col = $urandom_range(0, eff_width - 1);
					row = $urandom_range(0, img_height - 1);
				end
				send_pixel(col, row, 1'b0, PIX_OOR);
				sent++;
				calm = (sent > RANDOM_ITEMS - CALM_ITEMS);
			end
		end

		drain_pixels();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_pixels.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
